// ===== design/active_set_bound_update_core_macros.svh =====
// Assertion macros for the working-set core.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef ACTIVE_SET_BOUND_UPDATE_CORE_MACROS_SVH
`define ACTIVE_SET_BOUND_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define ASBU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASBU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/asbu_pkg.sv =====
package asbu_pkg;

	localparam int IDX_W        = 7;
	localparam int DATA_W       = 32;
	localparam int TOL_W        = 16;
	localparam int CNT_W        = 7;
	localparam int MAX_VARS_DEF = 64;

	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] REG_TOL_ADDR = '0;
	localparam logic [TOL_W-1:0]   TOL_RESET    = 16'd1;

	typedef enum logic [1:0] {
		REL_NOT_ASKED = 2'd0,
		REL_NONE      = 2'd1,
		REL_DONE      = 2'd2
	} rel_status_t;

	// per-item bound check results
	typedef struct packed {
		logic              at_any;
		logic              outward;
		logic [DATA_W-1:0] mag;
	} bound_flags_t;

endpackage

// ===== design/asbu_if.sv =====
interface asbu_in_if;
	logic                               valid;
	logic                               ready;
	logic [asbu_pkg::IDX_W-1:0]         var_index;
	logic signed [asbu_pkg::DATA_W-1:0] lower_bound;
	logic signed [asbu_pkg::DATA_W-1:0] upper_bound;
	logic signed [asbu_pkg::DATA_W-1:0] current_value;
	logic signed [asbu_pkg::DATA_W-1:0] gradient;
	logic                               last_item;
	logic                               release_by_step;
	logic                               release_by_convergence;

	modport source (
		output valid, var_index, lower_bound, upper_bound, current_value, gradient,
		       last_item, release_by_step, release_by_convergence,
		input  ready
	);
	modport sink (
		input  valid, var_index, lower_bound, upper_bound, current_value, gradient,
		       last_item, release_by_step, release_by_convergence,
		output ready
	);
endinterface

interface asbu_out_if;
	logic                       valid;
	logic                       ready;
	logic [asbu_pkg::IDX_W-1:0] out_index;
	logic                       in_set;
	logic                       newly_added;
	logic                       pass_done;
	logic [1:0]                 release_status;
	logic [asbu_pkg::IDX_W-1:0] released_index;
	logic [asbu_pkg::CNT_W-1:0] active_count;

	modport source (
		output valid, out_index, in_set, newly_added, pass_done, release_status,
		       released_index, active_count,
		input  ready
	);
	modport sink (
		input  valid, out_index, in_set, newly_added, pass_done, release_status,
		       released_index, active_count,
		output ready
	);
endinterface

// ===== design/asbu_bound_check.sv =====
module asbu_bound_check (
	input  logic signed [asbu_pkg::DATA_W-1:0] lower_bound,
	input  logic signed [asbu_pkg::DATA_W-1:0] upper_bound,
	input  logic signed [asbu_pkg::DATA_W-1:0] current_value,
	input  logic signed [asbu_pkg::DATA_W-1:0] gradient,
	input  logic [asbu_pkg::TOL_W-1:0]         tol,
	output asbu_pkg::bound_flags_t             flags
);
	localparam int DW = asbu_pkg::DATA_W;
	localparam int EW = DW + 1;

	logic signed [EW-1:0] d_hi, d_lo, tol_x, g_x;
	logic [EW-1:0]        a_hi, a_lo, tol_u;
	logic                 at_hi, at_lo, g_up, g_dn;

	always_comb begin
		tol_u = {{(EW-asbu_pkg::TOL_W){1'b0}}, tol};
		tol_x = $signed(tol_u);
		g_x   = $signed({gradient[DW-1], gradient});
		d_hi  = $signed({upper_bound[DW-1], upper_bound})
		      - $signed({current_value[DW-1], current_value});
		d_lo  = $signed({lower_bound[DW-1], lower_bound})
		      - $signed({current_value[DW-1], current_value});
		// |d| stays below 2^32, fits 33 bits unsigned
		a_hi  = d_hi[EW-1] ? EW'(-d_hi) : EW'(d_hi);
		a_lo  = d_lo[EW-1] ? EW'(-d_lo) : EW'(d_lo);
		at_hi = a_hi < tol_u;
		at_lo = a_lo < tol_u;
		g_up  = g_x > tol_x;
		g_dn  = g_x < -tol_x;

		flags.at_any  = at_hi || at_lo;
		flags.outward = (at_hi && g_up) || (at_lo && g_dn);
		flags.mag     = gradient[DW-1] ? DW'(-gradient) : DW'(gradient);
	end
endmodule

// ===== design/asbu_member_ram.sv =====
module asbu_member_ram #(
	parameter int DEPTH = asbu_pkg::MAX_VARS_DEF,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rd_data
);
	logic mem [DEPTH];
	logic rd_data_q;

	// read-before-write on a shared address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== design/active_set_bound_update_core.sv =====
// An accepted item is registered into stage 1; its result is then registered in the
// output register, from which it is taken when out_if.ready is high.
// Throughput: one item per cycle while the output is taken. A last item with a release
// request holds off the input: its add and release may both need the RAM write port.
// Reset: asynchronous, active low. Afterwards the membership RAM is swept to zero,
// one entry per cycle, with the input held off until the sweep ends; config is accepted.
`include "active_set_bound_update_core_macros.svh"

module active_set_bound_update_core #(
	parameter int MAX_VARS = asbu_pkg::MAX_VARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	asbu_in_if.sink                       in_if,
	asbu_out_if.source                    out_if,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [asbu_pkg::PADDR_W-1:0]  paddr,
	input  logic [asbu_pkg::PDATA_W-1:0]  pwdata,
	output logic [asbu_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	localparam int IDX_W = asbu_pkg::IDX_W;
	localparam int DW    = asbu_pkg::DATA_W;
	localparam int TOL_W = asbu_pkg::TOL_W;
	localparam int CNT_W = asbu_pkg::CNT_W;
	localparam int AW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int EXT   = IDX_W + AW;
	localparam logic [EXT-1:0] MAXV    = EXT'(MAX_VARS);
	localparam logic [AW-1:0]  LAST_AD = AW'(MAX_VARS - 1);

	// one-based index to RAM address
	function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
		logic [EXT-1:0] ext;
		ext = {{AW{1'b0}}, idx - IDX_W'(1)};
		return ext[AW-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Config register: bound tolerance
	// ---------------------------------------------------------------
	logic [TOL_W-1:0] tol_q;

	assign pready = 1'b1;
	assign prdata = (paddr == asbu_pkg::REG_TOL_ADDR)
	              ? {{(asbu_pkg::PDATA_W-TOL_W){1'b0}}, tol_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= asbu_pkg::TOL_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr == asbu_pkg::REG_TOL_ADDR) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Post-reset clearing sweep of the membership RAM
	// ---------------------------------------------------------------
	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == LAST_AD) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 0: bound and gradient checks on the incoming item.
	// Membership read is launched at the accepting edge.
	// ---------------------------------------------------------------
	asbu_pkg::bound_flags_t flags_in;
	logic                   accept;
	logic                   ok_in;

	asbu_bound_check u_check (
		.lower_bound   (in_if.lower_bound),
		.upper_bound   (in_if.upper_bound),
		.current_value (in_if.current_value),
		.gradient      (in_if.gradient),
		.tol           (tol_q),
		.flags         (flags_in)
	);

	assign ok_in  = (in_if.var_index != '0) && ({{AW{1'b0}}, in_if.var_index} <= MAXV);
	assign accept = in_if.valid && in_if.ready;

	// ---------------------------------------------------------------
	// Stage 1 registers
	// ---------------------------------------------------------------
	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [AW-1:0]          addr_s1;
	logic                   ok_s1;
	logic                   last_s1;
	logic                   req_s1;
	asbu_pkg::bound_flags_t flags_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= in_if.var_index;
			addr_s1  <= to_addr(in_if.var_index);
			ok_s1    <= ok_in;
			last_s1  <= in_if.last_item;
			req_s1   <= in_if.release_by_step || in_if.release_by_convergence;
			flags_s1 <= flags_in;
		end
	end

	// ---------------------------------------------------------------
	// Membership RAM and its write path
	// ---------------------------------------------------------------
	logic          rd_data;
	logic          mem_we, mem_wd;
	logic [AW-1:0] mem_wa;
	logic          s1_we, s1_wd;
	logic [AW-1:0] s1_wa;
	logic          pend_q;        // release deferred behind an add
	logic [AW-1:0] pend_addr_q;
	logic          fwd_valid_q;   // most recent RAM write, for the item read at that edge
	logic [AW-1:0] fwd_addr_q;
	logic          fwd_data_q;

	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = 1'b0;
		end else if (s1_we) begin
			mem_we = 1'b1;
			mem_wa = s1_wa;
			mem_wd = s1_wd;
		end else begin
			// a pending release only exists while stage 1 is empty
			mem_we = pend_q;
			mem_wa = pend_addr_q;
			mem_wd = 1'b0;
		end
	end

	asbu_member_ram #(
		.DEPTH (MAX_VARS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_wa),
		.wdata   (mem_wd),
		.re      (accept),
		.raddr   (to_addr(in_if.var_index)),
		.rd_data (rd_data)
	);

	// ---------------------------------------------------------------
	// Stage 1: resolve membership, candidate tracking, release
	// ---------------------------------------------------------------
	logic [DW-1:0]          best_mag_q;
	logic [IDX_W-1:0]       best_cand_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	logic                   out_free, adv, block;
	logic                   was_in, add, upd, rel, now_in;
	logic [IDX_W-1:0]       cand_nx;
	logic [DW-1:0]          mag_nx;
	logic [CNT_W-1:0]       cnt_nx;
	asbu_pkg::rel_status_t  status;

	assign out_free = !out_valid_q || out_if.ready;
	assign adv      = valid_s1 && out_free;
	// a requested pass end may need two RAM writes: hold the input off while it sits in stage 1
	assign block    = valid_s1 && last_s1 && req_s1;
	assign in_if.ready = !clr_busy_q && (!valid_s1 || adv) && !block;

	always_comb begin
		was_in  = ok_s1 && ((fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data);
		add     = ok_s1 && flags_s1.at_any && !was_in;
		upd     = was_in && flags_s1.outward && (flags_s1.mag > best_mag_q);
		cand_nx = upd ? idx_s1 : best_cand_q;
		mag_nx  = upd ? flags_s1.mag : best_mag_q;
		// a tracked candidate was a member when chosen and nothing leaves mid-pass
		rel     = last_s1 && req_s1 && (cand_nx != '0);
		now_in  = (was_in || add) && !(rel && cand_nx == idx_s1);

		if (last_s1 && req_s1) begin
			status = rel ? asbu_pkg::REL_DONE : asbu_pkg::REL_NONE;
		end else begin
			status = asbu_pkg::REL_NOT_ASKED;
		end

		if (add && !rel) begin
			cnt_nx = count_q + CNT_W'(1);
		end else if (rel && !add) begin
			cnt_nx = count_q - CNT_W'(1);
		end else begin
			cnt_nx = count_q;
		end

		s1_we = adv && (add || rel);
		s1_wa = add ? addr_s1 : to_addr(cand_nx);
		s1_wd = add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			best_mag_q  <= '0;
			best_cand_q <= '0;
			count_q     <= '0;
			pend_q      <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				best_mag_q  <= last_s1 ? '0 : mag_nx;
				best_cand_q <= last_s1 ? '0 : cand_nx;
				count_q     <= cnt_nx;
			end
			pend_q <= adv && add && rel;
			if (mem_we) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pend_addr_q <= to_addr(cand_nx);
		end
		if (mem_we) begin
			fwd_addr_q <= mem_wa;
			fwd_data_q <= mem_wd;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic [IDX_W-1:0] out_index_q, released_index_q;
	logic             in_set_q, newly_added_q, pass_done_q;
	logic [1:0]       release_status_q;
	logic [CNT_W-1:0] active_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_if.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_index_q      <= idx_s1;
			in_set_q         <= now_in;
			newly_added_q    <= add;
			pass_done_q      <= last_s1;
			release_status_q <= status;
			released_index_q <= rel ? cand_nx : '0;
			active_count_q   <= cnt_nx;
		end
	end

	assign out_if.valid          = out_valid_q;
	assign out_if.out_index      = out_index_q;
	assign out_if.in_set         = in_set_q;
	assign out_if.newly_added    = newly_added_q;
	assign out_if.pass_done      = pass_done_q;
	assign out_if.release_status = release_status_q;
	assign out_if.released_index = released_index_q;
	assign out_if.active_count   = active_count_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`ASBU_ASSERT_IMPL(a_pend_s1_empty, pend_q, !valid_s1, "deferred release with item in stage 1")
	`ASBU_ASSERT_IMPL(a_clr_no_accept, clr_busy_q, !in_if.ready, "input taken during RAM sweep")
	`ASBU_ASSERT_IMPL(a_rel_index, out_valid_q && release_status_q == asbu_pkg::REL_DONE,
		released_index_q != '0, "release reported without an index")
	`ASBU_ASSERT_NEXT(a_pass_clear, adv && last_s1,
		best_cand_q == '0 && best_mag_q == '0, "tracking not cleared at pass end")

endmodule
